// ===== sv/ezm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ezm_pkg: shared types and constants for the ellipsoid zone membership block
// Holds the operation codes, word selector codes, limits and the queue entry
// type that passes from the front part to the scan engine.
// ----------------------------------------------------------------------------
package ezm_pkg;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [4:0] SEL_RECIP0 = 5'd12;
    localparam logic [4:0] SEL_DAMAGE = 5'd15;
    localparam logic [4:0] SEL_SYSTEM = 5'd16;
    localparam logic [4:0] SEL_VALID  = 5'd17;

    localparam logic [15:0] DEATH_DAMAGE_MIN = 16'd250;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_SCAN,
        ENG_DONE
    } eng_state_t;

    typedef struct packed {
        logic        [31:0] system_id;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               death_only;
    } query_t;

endpackage : ezm_pkg
`default_nettype wire

// ===== sv/ezm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ezm_front: input classification and zone table
// Writes table words straight into the zone table and queues queries for the
// scan engine; answers writes with an all-zero result from a small queue.
// Writes wait while a query is queued or scanning so table order is kept;
// queries wait while a write result is still pending so results stay in order.
// ----------------------------------------------------------------------------
module ezm_front #(
    parameter int MAX_ZONES = 64
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire                 operation,
    input  wire  [5:0]          zone_index,
    input  wire  [4:0]          word_select,
    input  wire  [31:0]         word_value,
    input  ezm_pkg::query_t     query_in,
    // query queue to the engine (one entry)
    output logic                q_valid,
    input  wire                 q_ready,
    output ezm_pkg::query_t     q_data,
    input  wire                 eng_busy,
    // write acknowledge
    output logic                wack_valid,
    input  wire                 wack_ready,
    // table read by the engine
    input  wire  [$clog2(MAX_ZONES+1)-1:0] rd_zone,
    output logic [12*32-1:0]    rd_matrix,
    output logic [3*32-1:0]     rd_recip,
    output logic [15:0]         rd_damage,
    output logic [31:0]         rd_system,
    output logic                rd_valid_bit
);
    import ezm_pkg::*;

    localparam int ZW = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
    localparam int MW = 12*32 + 3*32 + 16 + 32;

    logic            q_valid_reg, q_valid_next;
    query_t          q_data_reg;
    logic            wack_reg, wack_next;
    logic [MAX_ZONES-1:0] valid_reg;
    logic            do_write, accept;
    logic [ZW-1:0]   wr_zone;
    logic            idx_ok;
    logic [MW-1:0]   wr_mask, wr_word, rd_word;
    logic [31:0]     dmg_sat;

    assign idx_ok  = ({26'd0, zone_index} < 32'(MAX_ZONES));
    assign wr_zone = zone_index[ZW-1:0];
    assign in_ready = (operation == OP_QUERY) ? (!q_valid_reg && (!wack_reg || wack_ready))
                    : (!q_valid_reg && !eng_busy && (!wack_reg || wack_ready));
    assign accept   = in_valid && in_ready;
    assign do_write = accept && (operation == OP_WRITE) && idx_ok;

    assign dmg_sat = (word_value > 32'hFFFF) ? 32'hFFFF : word_value;

    // Lay out the row: matrix words 0..11, recips 12..14, damage, system.
    always_comb
    begin
        wr_mask = '0;
        wr_word = '0;
        if (word_select < SEL_RECIP0)
        begin
            wr_mask[word_select[3:0]*32 +: 32] = '1;
            wr_word[word_select[3:0]*32 +: 32] = word_value;
        end
        else if (word_select < SEL_DAMAGE)
        begin
            wr_mask[(word_select - SEL_RECIP0)*32 + 384 +: 32] = '1;
            wr_word[(word_select - SEL_RECIP0)*32 + 384 +: 32] = word_value;
        end
        else if (word_select == SEL_DAMAGE)
        begin
            wr_mask[480 +: 16] = '1;
            wr_word[480 +: 16] = dmg_sat[15:0];
        end
        else if (word_select == SEL_SYSTEM)
        begin
            wr_mask[496 +: 32] = '1;
            wr_word[496 +: 32] = word_value;
        end
    end

    ezm_ram #(.WIDTH(MW), .DEPTH(MAX_ZONES)) u_table (
        .clk     (clk),
        .we      (do_write),
        .wr_addr (wr_zone),
        .wr_mask (wr_mask),
        .wr_data (wr_word),
        .rd_addr (rd_zone[ZW-1:0]),
        .rd_data (rd_word)
    );

    assign rd_matrix = rd_word[0 +: 384];
    assign rd_recip  = rd_word[384 +: 96];
    assign rd_damage = rd_word[480 +: 16];
    assign rd_system = rd_word[496 +: 32];

    // Valid bits are flip-flops; their read is registered to line up with the RAM.
    logic rd_vb_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_vb_reg <= 1'b0;
        end
        else
        begin
            if (do_write && word_select == SEL_VALID)
                valid_reg[wr_zone] <= word_value[0];
            rd_vb_reg <= valid_reg[rd_zone[ZW-1:0]];
        end
    end
    assign rd_valid_bit = rd_vb_reg;

    always_comb
    begin
        q_valid_next = q_valid_reg;
        if (q_valid_reg && q_ready)
            q_valid_next = 1'b0;
        if (accept && operation == OP_QUERY)
            q_valid_next = 1'b1;
        wack_next = wack_reg;
        if (wack_reg && wack_ready)
            wack_next = 1'b0;
        if (accept && operation == OP_WRITE)
            wack_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 1'b0;
            wack_reg    <= 1'b0;
        end
        else
        begin
            q_valid_reg <= q_valid_next;
            wack_reg    <= wack_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && operation == OP_QUERY)
            q_data_reg <= query_in;
    end

    assign q_valid    = q_valid_reg;
    assign q_data     = q_data_reg;
    assign wack_valid = wack_reg;

endmodule : ezm_front
`default_nettype wire

// ===== sv/ezm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ezm_ram: generic single-port-write, registered-read RAM
// One write with a bit mask and one read per cycle.
// ----------------------------------------------------------------------------
module ezm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire                              clk,
    input  wire                              we,
    input  wire  [$clog2(DEPTH>1?DEPTH:2)-1:0] wr_addr,
    input  wire  [WIDTH-1:0]                 wr_mask,
    input  wire  [WIDTH-1:0]                 wr_data,
    input  wire  [$clog2(DEPTH>1?DEPTH:2)-1:0] rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wr_addr] <= (mem[wr_addr] & ~wr_mask) | (wr_data & wr_mask);
        rd_data <= mem[rd_addr];
    end

endmodule : ezm_ram
`default_nettype wire

// ===== sv/ezm_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ezm_engine: zone scan engine
// Walks the zone table one entry at a time. For each candidate it runs a
// sequenced datapath: one 32x32 product per cycle, exact Q30 sums, then one
// magnitude-by-recip product and one square per axis.
// ----------------------------------------------------------------------------
module ezm_engine #(
    parameter int MAX_ZONES = 64
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 q_valid,
    output logic                q_ready,
    input  ezm_pkg::query_t     q_data,
    output logic                busy,
    output logic [$clog2(MAX_ZONES+1)-1:0] rd_zone,
    input  wire  [12*32-1:0]    rd_matrix,
    input  wire  [3*32-1:0]     rd_recip,
    input  wire  [15:0]         rd_damage,
    input  wire  [31:0]         rd_system,
    input  wire                 rd_valid_bit,
    output logic                res_valid,
    input  wire                 res_ready,
    output logic                res_hit,
    output logic [5:0]          res_zone,
    output logic [15:0]         res_damage
);
    import ezm_pkg::*;

    localparam int CW = $clog2(MAX_ZONES+1);

    eng_state_t state_reg, state_next;
    query_t     qry_reg;
    logic [CW-1:0] zone_reg, zone_next;
    // step: 0 wait RAM, 1 check, 2..10 products, 11..13 axis products,
    // 12..14 squares (one step behind), 15 decide
    logic [3:0] step_reg, step_next;
    logic [1:0] row_reg;
    logic signed [65:0] acc_reg;   // running sum of the current row's products
    logic signed [65:0] prod_reg;
    logic signed [35:0] u_reg [3];
    logic [67:0]  n_reg;
    logic [64:0]  lo_reg;
    logic [1:0]   carry_reg;
    logic         fail_reg;
    logic         hit_reg, found_reg;
    logic [5:0]   fz_reg;
    logic [15:0]  fd_reg;
    logic         cand;
    logic [1:0]   col;
    logic [1:0]   axis;
    logic signed [31:0] mcoef, pcoord;
    logic signed [63:0] mul;
    logic signed [35:0] u_new;
    logic [35:0]  mag;
    logic [31:0]  rc;
    logic [67:0]  n;
    logic [63:0]  sq;
    logic [64:0]  lo_sum;
    logic         scan_end;
    logic         inside_ok;

    assign busy    = (state_reg != ENG_IDLE);
    assign q_ready = (state_reg == ENG_IDLE);
    assign rd_zone = zone_reg;
    assign scan_end = (zone_reg == CW'(MAX_ZONES));

    assign cand = rd_valid_bit && (rd_system == qry_reg.system_id)
               && !(qry_reg.death_only && rd_damage <= DEATH_DAMAGE_MIN);

    // product step: row = (step-2)/3, col = (step-2)%3
    logic [3:0] ps;
    assign ps = step_reg - 4'd2;
    always_comb
    begin
        col = 2'd0;
        case (ps)
            4'd0, 4'd3, 4'd6: col = 2'd0;
            4'd1, 4'd4, 4'd7: col = 2'd1;
            4'd2, 4'd5, 4'd8: col = 2'd2;
            default:          col = 2'd0;
        endcase
    end
    always_comb
    begin
        mcoef = $signed(rd_matrix[({2'd0, row_reg}*4 + {2'd0, col})*32 +: 32]);
        case (col)
            2'd0:    pcoord = qry_reg.pos_x;
            2'd1:    pcoord = qry_reg.pos_y;
            default: pcoord = qry_reg.pos_z;
        endcase
        mul = mcoef * pcoord;
    end

    // Floor of the exact sum of the row's products, plus the row's offset word.
    assign u_new = 36'((acc_reg + 66'(mul)) >>> 30)
                 + 36'($signed(rd_matrix[({2'd0, row_reg}*4 + 3)*32 +: 32]));

    // axis of the magnitude product: steps 11, 12, 13 give 0, 1, 2
    assign axis = step_reg[1:0] - 2'd3;

    always_comb
    begin
        mag = u_reg[axis][35] ? 36'(-u_reg[axis]) : u_reg[axis];
        rc  = rd_recip[axis*32 +: 32];
        n   = 68'(mag) * 68'(rc);
        sq  = 64'(n_reg[31:0]) * 64'(n_reg[31:0]);
        lo_sum = {1'b0, lo_reg[63:0]} + {1'b0, sq};
    end

    assign inside_ok = !fail_reg && (carry_reg == 2'd0 ||
                       (carry_reg == 2'd1 && lo_reg[63:0] == 64'd0));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ENG_IDLE: if (q_valid) state_next = ENG_SCAN;
            ENG_SCAN: if ((step_reg == 4'd1 && (scan_end || (!cand && zone_reg ==
                          CW'(MAX_ZONES-1)))) || (step_reg == 4'd15 &&
                          (inside_ok || zone_reg == CW'(MAX_ZONES-1))))
                          state_next = ENG_DONE;
            ENG_DONE: if (res_ready) state_next = ENG_IDLE;
            default:  state_next = ENG_IDLE;
        endcase
    end

    always_comb
    begin
        zone_next = zone_reg;
        step_next = step_reg;
        case (state_reg)
            ENG_IDLE: begin zone_next = '0; step_next = 4'd0; end
            ENG_SCAN:
            begin
                if (step_reg == 4'd1 && !cand)
                begin
                    zone_next = zone_reg + 1'b1;
                    step_next = 4'd0;
                end
                else if (step_reg == 4'd15)
                begin
                    zone_next = zone_reg + 1'b1;
                    step_next = 4'd0;
                end
                else
                    step_next = step_reg + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ENG_IDLE;
            zone_reg  <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            zone_reg  <= zone_next;
            step_reg  <= step_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == ENG_IDLE && q_valid)
        begin
            qry_reg   <= q_data;
            found_reg <= 1'b0;
            hit_reg   <= 1'b0;
            fz_reg    <= '0;
            fd_reg    <= '0;
        end
        else if (state_reg == ENG_SCAN)
        begin
            if (step_reg == 4'd1)
            begin
                row_reg   <= 2'd0;
                acc_reg   <= '0;
                lo_reg    <= '0;
                carry_reg <= '0;
                fail_reg  <= 1'b0;
            end
            else if (step_reg <= 4'd10)
            begin
                if (col == 2'd2)
                begin
                    u_reg[row_reg] <= u_new;
                    acc_reg <= '0;
                    row_reg <= row_reg + 1'b1;
                end
                else
                    acc_reg <= acc_reg + 66'(mul);
            end
            else if (step_reg <= 4'd14)
            begin
                // a zero magnitude or recip gives a zero product: no term
                if (step_reg != 4'd14)
                    n_reg <= n;
                if (step_reg != 4'd11)
                begin
                    if (n_reg > 68'h1_0000_0000)
                        fail_reg <= 1'b1;
                    else if (n_reg == 68'h1_0000_0000)
                        carry_reg <= carry_reg + 1'b1;
                    else
                    begin
                        lo_reg <= {1'b0, lo_sum[63:0]};
                        if (lo_sum[64])
                            carry_reg <= carry_reg + 1'b1;
                    end
                end
            end
            else if (inside_ok)
            begin
                found_reg <= 1'b1;
                hit_reg   <= 1'b1;
                fz_reg    <= 6'(zone_reg);
                fd_reg    <= rd_damage;
            end
        end
    end

    assign res_valid  = (state_reg == ENG_DONE);
    assign res_hit    = hit_reg;
    assign res_zone   = fz_reg;
    assign res_damage = fd_reg;

endmodule : ezm_engine
`default_nettype wire

// ===== sv/ellipsoid_zone_membership_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ellipsoid_zone_membership_top: first ellipsoid zone containing a point
// Usage:
//   One input channel (in_valid/in_ready) carries either a zone table word
//   write or a membership query, selected by operation. Every transfer yields
//   exactly one result transfer on the output channel (out_valid/out_ready).
//   Writes return an all-zero result; a write waits while a query is queued
//   or being scanned, so table order is kept, and a query waits while a write
//   result is still pending, so results keep order. Queries go through a
//   one-entry queue to the scan engine, which visits the zones in index order:
//   for each zone it reads the RAM and applies the system, valid and damage
//   filter; a candidate zone then runs nine 32x32 products, three magnitude
//   products with each square in the cycle after its product, and one
//   decision. The scan stops at the first hit.
//   While the receiver stalls, results hold and the front still takes one
//   more query into its queue. Reset clears the valid bits of all zones and
//   empties the queue; the other table fields stay undefined until written.
//   Results leave in input order.
// ----------------------------------------------------------------------------
module ellipsoid_zone_membership_top #(
    parameter int MAX_ZONES = 64
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire         operation,
    input  wire  [5:0]  zone_index,
    input  wire  [4:0]  word_select,
    input  wire  [31:0] word_value,
    input  wire  [31:0] system_id,
    input  wire  signed [31:0] pos_x,
    input  wire  signed [31:0] pos_y,
    input  wire  signed [31:0] pos_z,
    input  wire         death_only,
    output logic        out_valid,
    input  wire         out_ready,
    output logic        hit,
    output logic [5:0]  found_zone,
    output logic [15:0] zone_damage
);
    import ezm_pkg::*;

    localparam int CW = $clog2(MAX_ZONES+1);

    query_t      query_in, q_data;
    logic        q_valid, q_ready, eng_busy;
    logic        wack_valid, wack_ready;
    logic [CW-1:0] rd_zone;
    logic [12*32-1:0] rd_matrix;
    logic [3*32-1:0]  rd_recip;
    logic [15:0] rd_damage;
    logic [31:0] rd_system;
    logic        rd_valid_bit;
    logic        res_valid, res_ready, res_hit;
    logic [5:0]  res_zone;
    logic [15:0] res_damage;

    assign query_in = '{system_id: system_id, pos_x: pos_x, pos_y: pos_y,
                        pos_z: pos_z, death_only: death_only};

    ezm_front #(.MAX_ZONES(MAX_ZONES)) u_front (
        .clk, .rst_n, .in_valid, .in_ready, .operation, .zone_index,
        .word_select, .word_value, .query_in,
        .q_valid, .q_ready, .q_data, .eng_busy,
        .wack_valid, .wack_ready,
        .rd_zone, .rd_matrix, .rd_recip, .rd_damage, .rd_system, .rd_valid_bit
    );

    ezm_engine #(.MAX_ZONES(MAX_ZONES)) u_engine (
        .clk, .rst_n, .q_valid, .q_ready, .q_data, .busy(eng_busy),
        .rd_zone, .rd_matrix, .rd_recip, .rd_damage, .rd_system, .rd_valid_bit,
        .res_valid, .res_ready, .res_hit, .res_zone, .res_damage
    );

    // Writes only issue while the engine is idle, so the two sources never
    // both hold a result; the engine's result takes precedence.
    assign out_valid   = res_valid || wack_valid;
    assign res_ready   = out_ready;
    assign wack_ready  = out_ready && !res_valid;
    assign hit         = res_valid ? res_hit    : 1'b0;
    assign found_zone  = res_valid ? res_zone   : 6'd0;
    assign zone_damage = res_valid ? res_damage : 16'd0;

endmodule : ellipsoid_zone_membership_top
`default_nettype wire
